FILE: rtl/lwtc_pkg.sv
package lwtc_pkg;

  // defaults for the top-level parameters
  localparam int CACHE_SLOTS_DEF     = 16;
  localparam int BLOCK_WORD_BITS_DEF = 64;

  // fixed field widths
  localparam int CFG_W  = 5;
  localparam int TAG_W  = 32;
  localparam int AGE_W  = 32;
  localparam int CNT_W  = 32;
  localparam int SLOT_W = 4;

  localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = 5'd16;

  // opcodes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_RESOLVE,
    ST_DONE
  } lwtc_state_e;

  // scan outcome flags
  typedef struct packed {
    logic hit;
    logic empty;
  } scan_flags_t;

endpackage

FILE: rtl/lwtc_scan.sv
module lwtc_scan
  import lwtc_pkg::*;
#(
  parameter int IDX_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             cmp_vld_i,
  input  logic [IDX_W-1:0] cmp_idx_i,
  input  logic             slot_valid_i,
  input  logic [TAG_W-1:0] slot_tag_i,
  input  logic [AGE_W-1:0] slot_age_i,
  input  logic [TAG_W-1:0] key_tag_i,
  output scan_flags_t      flags_o,
  output logic [IDX_W-1:0] hit_idx_o,
  output logic [IDX_W-1:0] free_idx_o,
  output logic [IDX_W-1:0] lru_idx_o
);

  scan_flags_t      flags_q, flags_d;
  logic             best_set_q, best_set_d;
  logic [AGE_W-1:0] best_age_q, best_age_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;

  // one slot per cycle: tag match, first empty, oldest age
  always_comb begin
    flags_d    = flags_q;
    best_set_d = best_set_q;
    best_age_d = best_age_q;
    hit_idx_d  = hit_idx_q;
    free_idx_d = free_idx_q;
    best_idx_d = best_idx_q;
    if (start_i) begin
      flags_d    = '0;
      best_set_d = 1'b0;
    end else if (cmp_vld_i) begin
      if (slot_valid_i) begin
        if (!flags_q.hit && slot_tag_i == key_tag_i) begin
          flags_d.hit = 1'b1;
          hit_idx_d   = cmp_idx_i;
        end
        // strict less keeps the lowest index on a tie
        if (!best_set_q || slot_age_i < best_age_q) begin
          best_set_d = 1'b1;
          best_age_d = slot_age_i;
          best_idx_d = cmp_idx_i;
        end
      end else if (!flags_q.empty) begin
        flags_d.empty = 1'b1;
        free_idx_d    = cmp_idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q    <= '0;
      best_set_q <= 1'b0;
    end else begin
      flags_q    <= flags_d;
      best_set_q <= best_set_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_age_q <= best_age_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    best_idx_q <= best_idx_d;
  end

  assign flags_o    = flags_q;
  assign hit_idx_o  = hit_idx_q;
  assign free_idx_o = free_idx_q;
  assign lru_idx_o  = best_idx_q;

endmodule

FILE: rtl/lru_write_through_cache_core.sv
// fully associative write-through cache, lru replacement, one slot compared per cycle
// one access at a time: the input stalls from the accepted beat until the result is loaded
// into the output register, and a stalled result side holds that load back
// the single tag/age compare unit walks the slots in turn for every access
// reset: valid bits, hit/miss counters and the access total clear at once, slot count
// returns to 16; tag, age and data memories are not cleared and need no clearing pass
module lru_write_through_cache_core
  import lwtc_pkg::*;
#(
  parameter int CACHE_SLOTS     = CACHE_SLOTS_DEF,
  parameter int BLOCK_WORD_BITS = BLOCK_WORD_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // slot count register write
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_W-1:0]           cfg_data_i,
  // access beat
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       opcode_i,
  input  logic [TAG_W-1:0]           block_number_i,
  input  logic [BLOCK_WORD_BITS-1:0] write_data_i,
  input  logic [BLOCK_WORD_BITS-1:0] lower_data_i,
  // result beat
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       hit_o,
  output logic [SLOT_W-1:0]          slot_o,
  output logic [BLOCK_WORD_BITS-1:0] read_data_o,
  output logic                       lower_read_o,
  output logic                       lower_write_o,
  output logic [CNT_W-1:0]           read_hit_count_o,
  output logic [CNT_W-1:0]           read_miss_count_o,
  output logic [CNT_W-1:0]           write_hit_count_o,
  output logic [CNT_W-1:0]           write_miss_count_o
);

  localparam int IDX_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
  localparam int NUM_W = $clog2(CACHE_SLOTS + 1);
  localparam int LIM_W = (NUM_W > CFG_W) ? NUM_W : CFG_W;

  lwtc_state_e state_q, state_d;

  // config register and effective slot count
  logic [CFG_W-1:0] slots_q;
  logic [LIM_W-1:0] cfg_ext;
  logic [LIM_W-1:0] active;
  logic [IDX_W-1:0] last_idx;

  // latched access
  logic                       op_q;
  logic [TAG_W-1:0]           tag_q;
  logic [BLOCK_WORD_BITS-1:0] wdata_q;
  logic [BLOCK_WORD_BITS-1:0] ldata_q;

  // slot storage
  logic [CACHE_SLOTS-1:0]     slot_valid_q;
  logic [TAG_W-1:0]           tag_mem [CACHE_SLOTS];
  logic [AGE_W-1:0]           age_mem [CACHE_SLOTS];
  logic [BLOCK_WORD_BITS-1:0] data_mem [CACHE_SLOTS];
  logic [TAG_W-1:0]           tag_rd_q;
  logic [AGE_W-1:0]           age_rd_q;
  logic [BLOCK_WORD_BITS-1:0] data_rd_q;

  // scan control
  logic [IDX_W-1:0] scan_idx_q, scan_idx_d;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             cmp_vld_q;

  scan_flags_t      flags;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] lru_idx;

  // resolved access
  logic [IDX_W-1:0] res_idx;
  logic [IDX_W-1:0] res_idx_q;
  logic             res_hit_q;
  logic             fill;

  // counters; the access total equals the wrapped sum of the four
  logic [CNT_W-1:0] rh_cnt_q, rm_cnt_q, wh_cnt_q, wm_cnt_q;
  logic [AGE_W-1:0] total_q;
  logic [AGE_W-1:0] total_inc;

  logic in_beat;
  logic load_out;
  logic out_valid_q;

  assign cfg_ready_o = 1'b1;

  // zero acts as one, anything above the slot count as the slot count
  assign cfg_ext = LIM_W'(slots_q);
  always_comb begin
    if (cfg_ext == '0) begin
      active = LIM_W'(1);
    end else if (cfg_ext > LIM_W'(CACHE_SLOTS)) begin
      active = LIM_W'(CACHE_SLOTS);
    end else begin
      active = cfg_ext;
    end
  end
  assign last_idx = IDX_W'(active - LIM_W'(1));

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_beat    = in_valid_i && !in_stall_o;

  // sequencer
  always_comb begin
    state_d    = state_q;
    scan_idx_d = scan_idx_q;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          state_d    = ST_SCAN;
          scan_idx_d = '0;
        end
      end
      ST_SCAN: begin
        // one slot address issued per cycle
        if (scan_idx_q == last_idx) begin
          state_d = ST_CHECK;
        end else begin
          scan_idx_d = scan_idx_q + IDX_W'(1);
        end
      end
      ST_CHECK: begin
        // last slot compared this cycle
        state_d = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!(out_valid_q && out_stall_i)) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      scan_idx_q <= '0;
      cmp_vld_q  <= 1'b0;
      slots_q    <= SLOTS_IN_USE_RST;
    end else begin
      state_q    <= state_d;
      scan_idx_q <= scan_idx_d;
      cmp_vld_q  <= (state_q == ST_SCAN);
      if (cfg_valid_i && cfg_ready_o) begin
        slots_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      op_q    <= opcode_i;
      tag_q   <= block_number_i;
      wdata_q <= write_data_i;
      ldata_q <= lower_data_i;
    end
  end

  // tag and age read for the slot under scan
  always_ff @(posedge clk_i) begin
    tag_rd_q  <= tag_mem[scan_idx_q];
    age_rd_q  <= age_mem[scan_idx_q];
    cmp_idx_q <= scan_idx_q;
  end

  lwtc_scan #(
    .IDX_W(IDX_W)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_beat),
    .cmp_vld_i   (cmp_vld_q),
    .cmp_idx_i   (cmp_idx_q),
    .slot_valid_i(slot_valid_q[cmp_idx_q]),
    .slot_tag_i  (tag_rd_q),
    .slot_age_i  (age_rd_q),
    .key_tag_i   (tag_q),
    .flags_o     (flags),
    .hit_idx_o   (hit_idx),
    .free_idx_o  (free_idx),
    .lru_idx_o   (lru_idx)
  );

  // hit slot, else first empty slot, else the oldest one
  always_comb begin
    if (flags.hit) begin
      res_idx = hit_idx;
    end else if (flags.empty) begin
      res_idx = free_idx;
    end else begin
      res_idx = lru_idx;
    end
  end

  assign fill      = !flags.hit || (op_q == OP_WRITE);
  assign total_inc = total_q + AGE_W'(1);

  // slot update and counting
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      rh_cnt_q     <= '0;
      rm_cnt_q     <= '0;
      wh_cnt_q     <= '0;
      wm_cnt_q     <= '0;
      total_q      <= '0;
    end else if (state_q == ST_RESOLVE) begin
      slot_valid_q[res_idx] <= 1'b1;
      total_q               <= total_inc;
      if (op_q == OP_WRITE) begin
        if (flags.hit) begin
          wh_cnt_q <= wh_cnt_q + CNT_W'(1);
        end else begin
          wm_cnt_q <= wm_cnt_q + CNT_W'(1);
        end
      end else begin
        if (flags.hit) begin
          rh_cnt_q <= rh_cnt_q + CNT_W'(1);
        end else begin
          rm_cnt_q <= rm_cnt_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RESOLVE) begin
      res_idx_q         <= res_idx;
      res_hit_q         <= flags.hit;
      age_mem[res_idx]  <= total_inc;
      if (!flags.hit) begin
        tag_mem[res_idx] <= tag_q;
      end
      if (fill) begin
        data_mem[res_idx] <= (op_q == OP_WRITE) ? wdata_q : ldata_q;
      end else begin
        // read hit fetches the cached word
        data_rd_q <= data_mem[res_idx];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= load_out || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      hit_o              <= res_hit_q;
      slot_o             <= SLOT_W'(res_idx_q);
      lower_read_o       <= (op_q == OP_READ) && !res_hit_q;
      lower_write_o      <= (op_q == OP_WRITE);
      read_hit_count_o   <= rh_cnt_q;
      read_miss_count_o  <= rm_cnt_q;
      write_hit_count_o  <= wh_cnt_q;
      write_miss_count_o <= wm_cnt_q;
      if (op_q == OP_WRITE) begin
        read_data_o <= '0;
      end else if (res_hit_q) begin
        read_data_o <= data_rd_q;
      end else begin
        read_data_o <= ldata_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // a result only appears out of the final sequencer step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the done step");

  // an accepted beat always starts a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (state_q == ST_SCAN))
    else $error("accepted beat did not start a scan");

  // a tag match is only ever taken from a valid slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESOLVE && flags.hit) |-> slot_valid_q[hit_idx])
    else $error("hit reported on an empty slot");

  // access total tracks the sum of the four counters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q == AGE_W'(rh_cnt_q + rm_cnt_q + wh_cnt_q + wm_cnt_q))
    else $error("access total out of step with counters");
`endif

endmodule

FILE: bench/lwtc_checker.sv
module lwtc_checker
  import lwtc_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [CFG_W-1:0]               cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic                           opcode_i,
  input  logic [TAG_W-1:0]               block_number_i,
  input  logic [BLOCK_WORD_BITS_DEF-1:0] write_data_i,
  input  logic [BLOCK_WORD_BITS_DEF-1:0] lower_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic                           hit_i,
  input  logic [SLOT_W-1:0]              slot_i,
  input  logic [BLOCK_WORD_BITS_DEF-1:0] read_data_i,
  input  logic                           lower_read_i,
  input  logic                           lower_write_i,
  input  logic [CNT_W-1:0]               read_hit_count_i,
  input  logic [CNT_W-1:0]               read_miss_count_i,
  input  logic [CNT_W-1:0]               write_hit_count_i,
  input  logic [CNT_W-1:0]               write_miss_count_i,
  output int                             errors_o,
  output int                             pending_o
);

  localparam int SLOTS      = CACHE_SLOTS_DEF;
  localparam int WB         = BLOCK_WORD_BITS_DEF;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [WB-1:0]     read_data;
    logic              lower_read;
    logic              lower_write;
    logic [CNT_W-1:0]  read_hits;
    logic [CNT_W-1:0]  read_misses;
    logic [CNT_W-1:0]  write_hits;
    logic [CNT_W-1:0]  write_misses;
  } access_result_t;

  // shadow copy of the cache contents and counters
  logic [CFG_W-1:0] slot_count_q;
  logic             line_valid_q [SLOTS];
  logic [TAG_W-1:0] line_tag_q   [SLOTS];
  logic [AGE_W-1:0] line_age_q   [SLOTS];
  logic [WB-1:0]    line_data_q  [SLOTS];
  logic [CNT_W-1:0] rd_hits_q, rd_misses_q, wr_hits_q, wr_misses_q;

  access_result_t pending_results_q[$];
  access_result_t oldest_r;

  function automatic access_result_t predict_access(logic op, logic [TAG_W-1:0] blk,
                                                    logic [WB-1:0] wdata,
                                                    logic [WB-1:0] ldata);
    int             n;
    int             idx;
    int             i;
    logic           found;
    logic [AGE_W-1:0] stamp;
    access_result_t r;
    if (slot_count_q == 0) n = 1;
    else if (int'(slot_count_q) > SLOTS) n = SLOTS;
    else n = int'(slot_count_q);
    found = 1'b0;
    idx   = 0;
    for (i = 0; i < n; i++) begin
      if (!found && line_valid_q[i] && line_tag_q[i] == blk) begin
        found = 1'b1;
        idx   = i;
      end
    end
    if (op == OP_WRITE) begin
      if (found) wr_hits_q++;
      else wr_misses_q++;
    end else begin
      if (found) rd_hits_q++;
      else rd_misses_q++;
    end
    stamp = rd_hits_q + rd_misses_q + wr_hits_q + wr_misses_q;
    if (!found) begin
      // first empty slot, else oldest stamp with lowest index on a tie
      idx = -1;
      for (i = 0; i < n; i++)
        if (idx < 0 && !line_valid_q[i]) idx = i;
      if (idx < 0) begin
        idx = 0;
        for (i = 1; i < n; i++)
          if (line_age_q[i] < line_age_q[idx]) idx = i;
      end
      line_valid_q[idx] = 1'b1;
      line_tag_q[idx]   = blk;
      line_data_q[idx]  = (op == OP_WRITE) ? wdata : ldata;
    end else if (op == OP_WRITE) begin
      line_data_q[idx] = wdata;
    end
    line_age_q[idx] = stamp;
    r.hit          = found;
    r.slot         = idx[SLOT_W-1:0];
    r.read_data    = (op == OP_WRITE) ? '0 : line_data_q[idx];
    r.lower_read   = (op == OP_READ) && !found;
    r.lower_write  = (op == OP_WRITE);
    r.read_hits    = rd_hits_q;
    r.read_misses  = rd_misses_q;
    r.write_hits   = wr_hits_q;
    r.write_misses = wr_misses_q;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors_o++;
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q = SLOTS_IN_USE_RST;
      for (int i = 0; i < SLOTS; i++) line_valid_q[i] = 1'b0;
      rd_hits_q   = '0;
      rd_misses_q = '0;
      wr_hits_q   = '0;
      wr_misses_q = '0;
      pending_results_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_results_q.size() == 0) begin
          errors_o++;
          $error("result beat with no access outstanding");
        end else begin
          oldest_r = pending_results_q.pop_front();
          check_field("hit", oldest_r.hit, hit_i);
          check_field("slot", oldest_r.slot, slot_i);
          check_field("read_data", oldest_r.read_data, read_data_i);
          check_field("lower_read", oldest_r.lower_read, lower_read_i);
          check_field("lower_write", oldest_r.lower_write, lower_write_i);
          check_field("read_hit_count", oldest_r.read_hits, read_hit_count_i);
          check_field("read_miss_count", oldest_r.read_misses, read_miss_count_i);
          check_field("write_hit_count", oldest_r.write_hits, write_hit_count_i);
          check_field("write_miss_count", oldest_r.write_misses, write_miss_count_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) slot_count_q = cfg_data_i;
      if (in_valid_i && !in_stall_i)
        pending_results_q.push_back(predict_access(opcode_i, block_number_i,
                                                   write_data_i, lower_data_i));
      pending_o = pending_results_q.size();
    end
  end

endmodule

FILE: bench/tb.sv
module tb
  import lwtc_pkg::*;
();

  localparam int WB              = BLOCK_WORD_BITS_DEF;
  localparam int ITEMS_PER_PHASE = 175;
  localparam int PHASES          = 10;
  localparam int POOL_SIZE       = 24;
  localparam int HOLD_CYCLES     = 400;
  localparam int HOLD_AFTER      = 200;
  // the limit covers the worst case access plus sender gap and receiver stall runs
  localparam int CYCLE_LIMIT     = 500000;
  localparam int DRAIN_CYCLES    = 40;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             opcode_i;
  logic [TAG_W-1:0] block_number_i;
  logic [WB-1:0]    write_data_i;
  logic [WB-1:0]    lower_data_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic             hit_o;
  logic [SLOT_W-1:0] slot_o;
  logic [WB-1:0]    read_data_o;
  logic             lower_read_o;
  logic             lower_write_o;
  logic [CNT_W-1:0] read_hit_count_o;
  logic [CNT_W-1:0] read_miss_count_o;
  logic [CNT_W-1:0] write_hit_count_o;
  logic [CNT_W-1:0] write_miss_count_o;

  int mismatches;
  int outstanding;

  // beats seen on each side, used to find the idle points between phases
  int in_beats;
  int out_beats;
  // sender burst bookkeeping
  int burst_left;
  // effective slot count, steers how many distinct blocks the stimulus touches
  int active_slots;
  logic [TAG_W-1:0] block_pool [POOL_SIZE];

  lru_write_through_cache_core DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .block_number_i    (block_number_i),
    .write_data_i      (write_data_i),
    .lower_data_i      (lower_data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .hit_o             (hit_o),
    .slot_o            (slot_o),
    .read_data_o       (read_data_o),
    .lower_read_o      (lower_read_o),
    .lower_write_o     (lower_write_o),
    .read_hit_count_o  (read_hit_count_o),
    .read_miss_count_o (read_miss_count_o),
    .write_hit_count_o (write_hit_count_o),
    .write_miss_count_o(write_miss_count_o)
  );

  lwtc_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .opcode_i          (opcode_i),
    .block_number_i    (block_number_i),
    .write_data_i      (write_data_i),
    .lower_data_i      (lower_data_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .hit_i             (hit_o),
    .slot_i            (slot_o),
    .read_data_i       (read_data_o),
    .lower_read_i      (lower_read_o),
    .lower_write_i     (lower_write_o),
    .read_hit_count_i  (read_hit_count_o),
    .read_miss_count_i (read_miss_count_o),
    .write_hit_count_i (write_hit_count_o),
    .write_miss_count_i(write_miss_count_o),
    .errors_o          (mismatches),
    .pending_o         (outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) out_beats++;
  end

  // one access beat; the sender idles between bursts of random length
  task automatic send_access(input logic op, input logic [TAG_W-1:0] blk,
                             input logic [WB-1:0] wdata, input logic [WB-1:0] ldata);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      // a quarter of the bursts follow on with no gap at all
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    block_number_i <= blk;
    write_data_i   <= wdata;
    lower_data_i   <= ldata;
    do @(posedge clk_i); while (in_stall_o);
    in_beats++;
  endtask

  // drop valid and wait until every result beat is back
  task automatic drain_accesses();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    wait (out_beats == in_beats);
  endtask

  // slot count register write, only issued while the cache is idle
  task automatic write_slot_count(input logic [CFG_W-1:0] count);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= count;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    // zero acts as one slot, anything above the slot count as all slots
    if (count == 0) active_slots = 1;
    else if (int'(count) > CACHE_SLOTS_DEF) active_slots = CACHE_SLOTS_DEF;
    else active_slots = int'(count);
  endtask

  // mostly blocks from a small pool so hits and lru evictions are frequent,
  // now and then an arbitrary block number
  task automatic random_access();
    int               span;
    logic [TAG_W-1:0] blk;
    span = (active_slots + 3 < POOL_SIZE) ? active_slots + 3 : POOL_SIZE - 1;
    if ($urandom_range(0, 9) == 0) blk = $urandom();
    else blk = block_pool[$urandom_range(0, span)];
    send_access($urandom_range(0, 1) ? OP_WRITE : OP_READ, blk,
                {$urandom(), $urandom()}, {$urandom(), $urandom()});
  endtask

  // receiver: stall pattern of its own, plus one long hold-off so the cache
  // backs up and stalls its input
  initial begin
    int   run_left;
    logic stall_level;
    logic held;
    out_stall_i = 1'b0;
    run_left    = 0;
    stall_level = 1'b0;
    held        = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && out_beats >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        run_left = 0;
      end
      if (run_left == 0) begin
        case ($urandom_range(0, 3))
          0: begin
            // long stretch that takes every beat
            stall_level = 1'b0;
            run_left    = $urandom_range(20, 80);
          end
          1: begin
            stall_level = 1'b1;
            run_left    = $urandom_range(1, 6);
          end
          default: begin
            stall_level = $urandom_range(0, 1);
            run_left    = $urandom_range(1, 4);
          end
        endcase
      end
      run_left--;
      out_stall_i <= stall_level;
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("tb: errors");
    $finish;
  end

  initial begin
    int phase_slots [PHASES];
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    opcode_i       = OP_READ;
    block_number_i = '0;
    write_data_i   = '0;
    lower_data_i   = '0;
    in_beats       = 0;
    out_beats      = 0;
    burst_left     = 0;
    active_slots   = int'(SLOTS_IN_USE_RST);

    // all-zero and all-ones block numbers live in the pool next to random ones
    block_pool[0] = '0;
    block_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) block_pool[i] = $urandom();

    // full size, single slot, zero and oversized counts, a shrink and regrow
    phase_slots = '{16, 1, 0, 31, 5, 16, 17, 2, 12, 16};
    phase_slots[7] = $urandom_range(1, 16);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: miss and hit on both opcodes at the reset slot count
    send_access(OP_READ, '0, '0, '0);
    send_access(OP_READ, '0, '1, '1);                    // read hit ignores lower data
    send_access(OP_WRITE, '1, '1, '0);                   // all-ones block is a normal tag
    send_access(OP_READ, '1, '0, '0);
    send_access(OP_WRITE, '0, 64'h8000_0000_0000_0001, '1);
    send_access(OP_READ, '0, '0, 64'h5555_5555_5555_5555);
    // fill every remaining slot
    for (int i = 2; i < CACHE_SLOTS_DEF; i++)
      send_access(i[0] ? OP_WRITE : OP_READ, i, {$urandom(), $urandom()},
                  {$urandom(), $urandom()});
    // cache full: the least recently touched slots get replaced
    send_access(OP_READ, 32'h8000_0000, '0, '1);
    send_access(OP_WRITE, 32'h0000_1000, '1, '0);
    send_access(OP_READ, '1, '1, 64'hAAAA_AAAA_AAAA_AAAA);
    drain_accesses();

    for (int p = 0; p < PHASES; p++) begin
      write_slot_count(CFG_W'(phase_slots[p]));
      repeat (ITEMS_PER_PHASE) random_access();
      drain_accesses();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
